>>> src/tcac_pkg.sv
// Shared types, codes and helper functions for the timed claw actuator control.
// Used by the register file, the motion controller, the top level and the checker.
package tcac_pkg;

   localparam int unsigned TRAVEL_W    = 16;
   localparam int unsigned CSR_INDEX_W = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_TRAVEL  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_TRAVEL = 1'b1;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_OPEN    = 2'd1,
      MODE_CLOSE   = 2'd2,
      MODE_DISABLE = 2'd3
   } mode_type;

   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_RUNNING = 2'd1;
   localparam logic [1:0] RES_FAILED  = 2'd2;

   localparam logic [2:0] POS_UNINIT  = 3'd0;
   localparam logic [2:0] POS_UNKNOWN = 3'd1;
   localparam logic [2:0] POS_OPENING = 3'd2;
   localparam logic [2:0] POS_OPENED  = 3'd3;
   localparam logic [2:0] POS_CLOSING = 3'd4;
   localparam logic [2:0] POS_CLOSED  = 3'd5;

   typedef enum logic [4:0] {
      MOTION_UNKNOWN = 5'b00001,
      MOTION_OPENING = 5'b00010,
      MOTION_OPENED  = 5'b00100,
      MOTION_CLOSING = 5'b01000,
      MOTION_CLOSED  = 5'b10000
   } motion_type;

   typedef struct packed {
      logic [TRAVEL_W-1:0] open_travel;
      logic [TRAVEL_W-1:0] close_travel;
      logic                open_missing;
      logic                close_missing;
   } cfg_type;

   typedef struct packed {
      logic [1:0] command_result;
      logic [2:0] position_state;
      logic       drive_forward;
      logic       drive_reverse;
      logic       drive_enable;
      logic       open_time_missing;
      logic       close_time_missing;
   } rsp_type;

   // The reported position reads as uninitialized while either travel time is unset.
   function automatic logic [2:0] position_code(motion_type motion, logic missing);
      logic [2:0] code;
      unique case (motion)
         MOTION_UNKNOWN: code = POS_UNKNOWN;
         MOTION_OPENING: code = POS_OPENING;
         MOTION_OPENED:  code = POS_OPENED;
         MOTION_CLOSING: code = POS_CLOSING;
         MOTION_CLOSED:  code = POS_CLOSED;
         default:        code = POS_UNKNOWN;
      endcase
      return missing ? POS_UNINIT : code;
   endfunction

endpackage

>>> src/tcac_csr.sv
// Travel time configuration registers of the timed claw actuator control.
// Depends on tcac_pkg for the register indexes and the configuration struct.
module tcac_csr
   import tcac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TRAVEL_W-1:0]    csr_wdata,
   output cfg_type                cfg
);

   logic [TRAVEL_W-1:0] open_travel_ff, open_travel_in;
   logic [TRAVEL_W-1:0] close_travel_ff, close_travel_in;

   always_comb begin
      open_travel_in  = open_travel_ff;
      close_travel_in = close_travel_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OPEN_TRAVEL:  open_travel_in  = csr_wdata;
            CSR_CLOSE_TRAVEL: close_travel_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_travel_ff  <= '0;
         close_travel_ff <= '0;
      end else begin
         open_travel_ff  <= open_travel_in;
         close_travel_ff <= close_travel_in;
      end
   end

   assign cfg.open_travel   = open_travel_ff;
   assign cfg.close_travel  = close_travel_ff;
   assign cfg.open_missing  = (open_travel_ff == '0);
   assign cfg.close_missing = (close_travel_ff == '0);

endmodule

>>> src/tcac_ctrl.sv
// Motion state machine and travel countdown of the timed claw actuator control.
// Depends on tcac_pkg; produces the result of the item presented on its inputs.
module tcac_ctrl
   import tcac_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_valid,
   input  mode_type item_mode,
   input  logic     item_kill,
   input  cfg_type  cfg,
   output rsp_type  rsp
);

   motion_type          motion_ff, motion_in;
   logic [TRAVEL_W-1:0] remaining_ff, remaining_in;
   logic [1:0]          result;
   logic                moving;
   logic                missing;
   logic                cmd_open;
   motion_type          done_st, moving_st, opposite_st;
   logic [TRAVEL_W-1:0] travel;

   assign moving   = (motion_ff == MOTION_OPENING) || (motion_ff == MOTION_CLOSING);
   assign missing  = cfg.open_missing || cfg.close_missing;
   assign cmd_open = (item_mode == MODE_OPEN);

   // Open and close share one command path; only the target states and the travel time differ.
   assign done_st     = cmd_open ? MOTION_OPENED  : MOTION_CLOSED;
   assign moving_st   = cmd_open ? MOTION_OPENING : MOTION_CLOSING;
   assign opposite_st = cmd_open ? MOTION_CLOSED  : MOTION_OPENED;
   assign travel      = cmd_open ? cfg.open_travel : cfg.close_travel;

   always_comb begin
      motion_in    = motion_ff;
      remaining_in = remaining_ff;
      result       = RES_OK;
      unique case (item_mode)
         MODE_TICK: begin
            if (moving) begin
               // A count already at zero also ends the motion on this tick.
               if (remaining_ff <= TRAVEL_W'(1)) begin
                  remaining_in = '0;
                  motion_in    = (motion_ff == MOTION_OPENING) ? MOTION_OPENED
                                                               : MOTION_CLOSED;
               end else begin
                  remaining_in = remaining_ff - TRAVEL_W'(1);
               end
            end
         end
         MODE_OPEN, MODE_CLOSE: begin
            priority if (item_kill) begin
               result = RES_FAILED;
            end else if (missing) begin
               result = RES_FAILED;
            end else if (motion_ff == done_st) begin
               result = RES_OK;
            end else if (motion_ff == moving_st) begin
               result = RES_RUNNING;
            end else if ((motion_ff == MOTION_UNKNOWN) || (motion_ff == opposite_st)) begin
               motion_in    = moving_st;
               remaining_in = travel;
               result       = RES_RUNNING;
            end else begin
               result = RES_FAILED;
            end
         end
         MODE_DISABLE: begin
            if (moving) begin
               motion_in    = MOTION_UNKNOWN;
               remaining_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff    <= MOTION_UNKNOWN;
         remaining_ff <= '0;
      end else if (item_valid) begin
         motion_ff    <= motion_in;
         remaining_ff <= remaining_in;
      end
   end

   // The result reflects the state after the item.
   assign rsp.command_result     = result;
   assign rsp.position_state     = position_code(motion_in, missing);
   assign rsp.drive_forward      = (motion_in == MOTION_OPENING);
   assign rsp.drive_reverse      = (motion_in == MOTION_CLOSING);
   assign rsp.drive_enable       = (motion_in == MOTION_OPENING) ||
                                   (motion_in == MOTION_CLOSING);
   assign rsp.open_time_missing  = cfg.open_missing;
   assign rsp.close_time_missing = cfg.close_missing;

endmodule

>>> src/timed_claw_actuator_control.sv
// Timed claw actuator control, top level: input register, controller, result register.
// Depends on tcac_pkg, tcac_csr and tcac_ctrl.
//
// Usage: each req transfer carries one item (tick, open, close or safety disable)
// plus the kill input level, and produces exactly one rsp transfer with the
// command result, the reported position and the H-bridge drive lines as they
// stand after the item. Both channels use valid/ready.
// A req transfer is captured in the input register and then moved into the result
// register, which drives rsp_valid, once that register is free or draining.
// Throughput is one item per cycle while the receiver keeps up; the controller
// state is updated as an item moves from the input register into the result
// register, so items are handled strictly in order.
// When the receiver stalls, the result register holds its transfer and the input
// register still takes one more item; req_ready drops only when both are full.
// Travel times must be written through the csr port only while no item is in flight;
// the block does not enforce it. Reset (synchronous) clears both travel times,
// empties both registers and puts the claw in the unknown position with the bridge off.
module timed_claw_actuator_control
   import tcac_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic                   req_kill_active,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_command_result,
   output logic [2:0]             rsp_position_state,
   output logic                   rsp_drive_forward,
   output logic                   rsp_drive_reverse,
   output logic                   rsp_drive_enable,
   output logic                   rsp_open_time_missing,
   output logic                   rsp_close_time_missing,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TRAVEL_W-1:0]    csr_wdata
);

   logic     in_valid_ff, in_valid_in;
   mode_type in_mode_ff;
   logic     in_kill_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_next;
   cfg_type  cfg;
   logic     advance;
   logic     req_xfer;

   tcac_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   tcac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item_mode  (in_mode_ff),
      .item_kill  (in_kill_ff),
      .cfg        (cfg),
      .rsp        (rsp_next)
   );

   // An item leaves the input register when the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff <= mode_type'(req_mode);
         in_kill_ff <= req_kill_active;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_command_result     = rsp_ff.command_result;
   assign rsp_position_state     = rsp_ff.position_state;
   assign rsp_drive_forward      = rsp_ff.drive_forward;
   assign rsp_drive_reverse      = rsp_ff.drive_reverse;
   assign rsp_drive_enable       = rsp_ff.drive_enable;
   assign rsp_open_time_missing  = rsp_ff.open_time_missing;
   assign rsp_close_time_missing = rsp_ff.close_time_missing;

endmodule

>>> src/tcac_checker.sv
// Port-level assertions for the timed claw actuator control, bound to the top level.
// Depends on tcac_pkg for the position codes.
module tcac_checker
   import tcac_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_position_state,
   input logic       rsp_drive_forward,
   input logic       rsp_drive_reverse,
   input logic       rsp_drive_enable
);

   // After reset both registers are empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input blocked after reset");

   // A stalled result transfer holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position_state)))
      else $error("stalled result transfer changed");

   // The input side can only block when a result is waiting on the receiver.
   a_block_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input blocked with no result pending");

   a_bridge_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive_enable == (rsp_drive_forward || rsp_drive_reverse)) &&
                     !(rsp_drive_forward && rsp_drive_reverse)))
      else $error("inconsistent H-bridge drive lines");

   a_forward_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_forward) |->
         ((rsp_position_state == POS_OPENING) || (rsp_position_state == POS_UNINIT)))
      else $error("forward drive without opening position");

endmodule

bind timed_claw_actuator_control tcac_checker u_tcac_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_position_state (rsp_position_state),
   .rsp_drive_forward  (rsp_drive_forward),
   .rsp_drive_reverse  (rsp_drive_reverse),
   .rsp_drive_enable   (rsp_drive_enable)
);
